FILE: design/arpc_pkg.sv
package arpc_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int MIN_FRAME = 42;

  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int OPCODE_W = 16;
  localparam int FLEN_W   = 12;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [OPCODE_W-1:0] ARP_OP_REQUEST = 16'd1;

  localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LOOKUP   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd2;

endpackage

FILE: design/arpc_ifs.sv
interface arpc_in_if;
  logic                            valid;
  logic                            ready;
  logic [arpc_pkg::KIND_W-1:0]     kind;
  logic [arpc_pkg::IP_W-1:0]       addr;
  logic [arpc_pkg::MAC_W-1:0]      hw_addr;
  logic [arpc_pkg::OPCODE_W-1:0]   arp_opcode;
  logic [arpc_pkg::IP_W-1:0]       target_addr;
  logic [arpc_pkg::FLEN_W-1:0]     frame_length;

  modport source (output valid, kind, addr, hw_addr, arp_opcode, target_addr, frame_length,
                  input ready);
  modport sink (input valid, kind, addr, hw_addr, arp_opcode, target_addr, frame_length,
                output ready);
endinterface

interface arpc_out_if;
  logic                            valid;
  logic                            ready;
  logic [arpc_pkg::STATUS_W-1:0]   status;
  logic                            found;
  logic [arpc_pkg::MAC_W-1:0]      found_hw_addr;
  logic                            reply_valid;
  logic [arpc_pkg::MAC_W-1:0]      reply_dest_hw_addr;
  logic [arpc_pkg::IP_W-1:0]       reply_target_addr;

  modport source (output valid, status, found, found_hw_addr, reply_valid,
                  reply_dest_hw_addr, reply_target_addr, input ready);
  modport sink (input valid, status, found, found_hw_addr, reply_valid,
                reply_dest_hw_addr, reply_target_addr, output ready);
endinterface

interface arpc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [arpc_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [arpc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

FILE: design/arp_cache_responder.sv
// ARP cache responder: a table of IPv4-to-MAC pairs, filled in arrival order.
// The in_if channel carries one item per transaction: a received ARP frame, a
// static add or a lookup. The out_if channel returns exactly one result per
// item, in order. The cfg_if channel writes own IP, gateway address and own MAC
// and is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. After an item is taken, one shared
// comparator walks the stored entries one per cycle through a registered table
// read and stops at the first match. An ignored item skips the scan. When the
// scan ends, the result goes into the output register once that register is
// free; in_if is ready only in the idle state, so not during the scan. The
// result is held in an output register, so the next item may be taken while it
// waits; if the receiver still stalls when the following result is ready, the
// block holds that result and stays busy until the register frees.
// Synchronous reset empties the table and clears the configuration registers.
module arp_cache_responder (
  input  logic         clk,
  input  logic         rst_n,
  arpc_in_if.sink      in_if,
  arpc_out_if.source   out_if,
  arpc_cfg_if.sink     cfg_if
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE
  } state_t;

  localparam logic [arpc_pkg::CNT_W-1:0] FULL_COUNT = arpc_pkg::CNT_W'(arpc_pkg::ENTRIES);

  logic [arpc_pkg::IP_W-1:0]  entry_ip  [arpc_pkg::ENTRIES];
  logic [arpc_pkg::MAC_W-1:0] entry_mac [arpc_pkg::ENTRIES];
  logic [arpc_pkg::IP_W-1:0]  rd_ip_r;
  logic [arpc_pkg::MAC_W-1:0] rd_mac_r;

  logic                        mem_we;
  logic [arpc_pkg::IDX_W-1:0]  mem_waddr;

  logic [arpc_pkg::IP_W-1:0]  own_ip_r;
  logic [arpc_pkg::IP_W-1:0]  gateway_r;
  logic [arpc_pkg::MAC_W-1:0] own_mac_r;

  state_t                        state_r, state_nxt;
  logic [arpc_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [arpc_pkg::CNT_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic                          pend_r, pend_nxt;
  logic [arpc_pkg::IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic                          hit_r, hit_nxt;
  logic [arpc_pkg::IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [arpc_pkg::MAC_W-1:0]    hit_mac_r, hit_mac_nxt;

  logic [arpc_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [arpc_pkg::IP_W-1:0]     addr_r, addr_nxt;
  logic [arpc_pkg::MAC_W-1:0]    hw_r, hw_nxt;
  logic                          ignore_r, ignore_nxt;
  logic                          reply_r, reply_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [arpc_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic                            out_found_r, out_found_nxt;
  logic [arpc_pkg::MAC_W-1:0]      out_found_mac_r, out_found_mac_nxt;
  logic                            out_reply_r, out_reply_nxt;
  logic [arpc_pkg::MAC_W-1:0]      out_reply_mac_r, out_reply_mac_nxt;
  logic [arpc_pkg::IP_W-1:0]       out_reply_ip_r, out_reply_ip_nxt;

  logic in_fire;
  logic slot_free;
  logic addr_match;
  logic frame_ok;

  assign in_if.ready  = (state_r == S_IDLE);
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign slot_free    = !out_valid_r || out_if.ready;
  assign addr_match   = (rd_ip_r == addr_r);

  assign frame_ok = (in_if.frame_length >= arpc_pkg::FLEN_W'(arpc_pkg::MIN_FRAME)) &&
                    (in_if.addr != gateway_r);

  assign out_if.valid              = out_valid_r;
  assign out_if.status             = out_status_r;
  assign out_if.found              = out_found_r;
  assign out_if.found_hw_addr      = out_found_mac_r;
  assign out_if.reply_valid        = out_reply_r;
  assign out_if.reply_dest_hw_addr = out_reply_mac_r;
  assign out_if.reply_target_addr  = out_reply_ip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      gateway_r <= '0;
      own_mac_r <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.reg_index)
        arpc_pkg::CFG_OWN_IP:  own_ip_r  <= cfg_if.data[arpc_pkg::IP_W-1:0];
        arpc_pkg::CFG_GATEWAY: gateway_r <= cfg_if.data[arpc_pkg::IP_W-1:0];
        arpc_pkg::CFG_OWN_MAC: own_mac_r <= cfg_if.data[arpc_pkg::MAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_ip_r  <= entry_ip[scan_idx_r[arpc_pkg::IDX_W-1:0]];
    rd_mac_r <= entry_mac[scan_idx_r[arpc_pkg::IDX_W-1:0]];
    if (mem_we) begin
      entry_ip[mem_waddr]  <= addr_r;
      entry_mac[mem_waddr] <= hw_r;
    end
  end

  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    scan_idx_nxt      = scan_idx_r;
    pend_nxt          = 1'b0;
    pend_idx_nxt      = pend_idx_r;
    hit_nxt           = hit_r;
    hit_idx_nxt       = hit_idx_r;
    hit_mac_nxt       = hit_mac_r;
    kind_nxt          = kind_r;
    addr_nxt          = addr_r;
    hw_nxt            = hw_r;
    ignore_nxt        = ignore_r;
    reply_nxt         = reply_r;
    out_valid_nxt     = out_valid_r && !out_if.ready;
    out_status_nxt    = out_status_r;
    out_found_nxt     = out_found_r;
    out_found_mac_nxt = out_found_mac_r;
    out_reply_nxt     = out_reply_r;
    out_reply_mac_nxt = out_reply_mac_r;
    out_reply_ip_nxt  = out_reply_ip_r;
    mem_we            = 1'b0;
    mem_waddr         = hit_idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt     = in_if.kind;
          addr_nxt     = in_if.addr;
          hw_nxt       = in_if.hw_addr;
          ignore_nxt   = (in_if.kind == arpc_pkg::KIND_FRAME) ? !frame_ok :
                         (in_if.kind != arpc_pkg::KIND_ADD) &&
                         (in_if.kind != arpc_pkg::KIND_LOOKUP);
          reply_nxt    = (in_if.kind == arpc_pkg::KIND_FRAME) && frame_ok &&
                         (in_if.arp_opcode == arpc_pkg::ARP_OP_REQUEST) &&
                         (in_if.target_addr == own_ip_r);
          scan_idx_nxt = '0;
          hit_nxt      = 1'b0;
          state_nxt    = ignore_nxt ? S_RESOLVE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (pend_r && addr_match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = pend_idx_r;
          hit_mac_nxt = rd_mac_r;
          state_nxt   = S_RESOLVE;
        end else if (scan_idx_r < count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r[arpc_pkg::IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + 1'b1;
        end else begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_found_nxt     = 1'b0;
          out_found_mac_nxt = '0;
          out_reply_nxt     = reply_r;
          out_reply_mac_nxt = reply_r ? hw_r : '0;
          out_reply_ip_nxt  = reply_r ? addr_r : '0;
          if (ignore_r) begin
            out_status_nxt = arpc_pkg::ST_IGNORED;
          end else if (kind_r == arpc_pkg::KIND_LOOKUP) begin
            out_status_nxt    = arpc_pkg::ST_LOOKUP;
            out_found_nxt     = hit_r;
            out_found_mac_nxt = hit_r ? hit_mac_r : '0;
          end else if (hit_r) begin
            out_status_nxt = arpc_pkg::ST_UPDATED;
            mem_we         = 1'b1;
          end else if (count_r != FULL_COUNT) begin
            out_status_nxt = arpc_pkg::ST_INSERTED;
            mem_we         = 1'b1;
            mem_waddr      = count_r[arpc_pkg::IDX_W-1:0];
            count_nxt      = count_r + 1'b1;
          end else begin
            out_status_nxt = arpc_pkg::ST_FULL;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    scan_idx_r      <= scan_idx_nxt;
    pend_idx_r      <= pend_idx_nxt;
    hit_r           <= hit_nxt;
    hit_idx_r       <= hit_idx_nxt;
    hit_mac_r       <= hit_mac_nxt;
    kind_r          <= kind_nxt;
    addr_r          <= addr_nxt;
    hw_r            <= hw_nxt;
    ignore_r        <= ignore_nxt;
    reply_r         <= reply_nxt;
    out_status_r    <= out_status_nxt;
    out_found_r     <= out_found_nxt;
    out_found_mac_r <= out_found_mac_nxt;
    out_reply_r     <= out_reply_nxt;
    out_reply_mac_r <= out_reply_mac_nxt;
    out_reply_ip_r  <= out_reply_ip_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("Entry count exceeds the table depth.");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> scan_idx_r <= count_r)
    else $error("Scan pointer has passed the entry count.");

  a_count_insert: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && count_r != $past(count_r) |->
      out_valid_r && out_status_r == arpc_pkg::ST_INSERTED)
    else $error("Entry count changed without an insert result.");

  a_found_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> out_status_r == arpc_pkg::ST_LOOKUP)
    else $error("Hit reported for a transaction that is not a lookup.");
`endif

endmodule
